[rtl/mfh_pkg.sv]
`default_nettype none

package mfh_pkg;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LSB_SCALE  = 2'd0,
      REG_ANGLE_UNIT = 2'd1
   } csr_index_type;

   localparam logic [15:0] LSB_SCALE_RESET  = 16'd614;
   localparam logic        ANGLE_UNIT_RESET = 1'b0;

   // Angle unit codes
   localparam logic UNIT_DEGREES = 1'b0;
   localparam logic UNIT_RADIANS = 1'b1;

   // Square root: one result bit per stage
   localparam int unsigned SQRT_STEPS = 32;

   // CORDIC
   localparam int unsigned CORDIC_STEPS_DEF = 16;
   localparam int unsigned ATAN_ENTRIES     = 24;
   localparam int unsigned CW               = 36;   // x/y datapath width
   localparam int unsigned ZW               = 32;   // angle accumulator, Q28 radians

   localparam logic [27:0] ATAN_Q28 [ATAN_ENTRIES] = '{
      28'd210828714, 28'd124459457, 28'd65760959, 28'd33381290, 28'd16755422,
      28'd8385879,   28'd4193963,   28'd2097109,  28'd1048571,  28'd524287,
      28'd262144,    28'd131072,    28'd65536,    28'd32768,    28'd16384,
      28'd8192,      28'd4096,      28'd2048,     28'd1024,     28'd512,
      28'd256,       28'd128,       28'd64,       28'd32
   };

   // 128 * 180 / pi in Q16
   localparam logic [28:0] DEG128_PER_RAD_Q16 = 29'd480631834;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_state_type;

   typedef struct packed {
      logic                 zero;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [ZW-1:0] z;
   } cordic_type;

   // Per-request data that rides along the pipeline
   typedef struct packed {
      logic               err;
      logic               range_b;
      logic               unit;
      logic               scale_zero;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic signed [15:0] z;
      logic signed [23:0] fx;
      logic signed [23:0] fy;
      logic signed [23:0] fz;
      logic [23:0]        mag;
   } side_type;

   // One bit of the restoring square root
   function automatic sqrt_state_type sqrt_step(sqrt_state_type s, int unsigned k);
      logic [63:0]    bitv;
      logic [63:0]    trial;
      sqrt_state_type r;
      bitv  = 64'd1 << (62 - 2 * k);
      trial = s.root + bitv;
      if (s.rem >= trial) begin
         r.rem  = s.rem - trial;
         r.root = (s.root >> 1) + bitv;
      end else begin
         r.rem  = s.rem;
         r.root = s.root >> 1;
      end
      return r;
   endfunction

   // Turn a left half-plane vector by +-90 degrees and flag the zero vector
   function automatic cordic_type cordic_init(logic signed [CW-1:0] x,
                                              logic signed [CW-1:0] y);
      cordic_type r;
      r.zero = (x == '0) && (y == '0);
      r.x    = x;
      r.y    = y;
      r.z    = '0;
      if (x[CW-1]) begin
         if (!y[CW-1]) begin
            r.x = y;
            r.y = -x;
            r.z = $signed({3'b000, ATAN_Q28[0], 1'b0});
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -$signed({3'b000, ATAN_Q28[0], 1'b0});
         end
      end
      return r;
   endfunction

   // One vectoring micro-rotation
   function automatic cordic_type cordic_step(cordic_type s, int unsigned i);
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic signed [ZW-1:0] a;
      cordic_type           r;
      dx = s.y >>> i;
      dy = s.x >>> i;
      a  = $signed({4'b0000, ATAN_Q28[i]});
      r.zero = s.zero;
      if (!s.y[CW-1]) begin
         r.x = s.x + dx;
         r.y = s.y - dy;
         r.z = s.z + a;
      end else begin
         r.x = s.x - dx;
         r.y = s.y + dy;
         r.z = s.z - a;
      end
      return r;
   endfunction

   // Round and saturate an angle magnitude to the 16-bit output code
   function automatic logic [15:0] angle_fmt(logic neg, logic [30:0] m,
                                             logic [59:0] p, logic unit);
      logic [31:0] rsum;
      logic [59:0] dsum;
      logic [16:0] q;
      logic [15:0] r;
      rsum = {1'b0, m} + 32'd16384;
      dsum = p + (60'd1 << 43);
      if (unit == UNIT_RADIANS) begin
         q = rsum[31:15];
      end else begin
         q = {1'b0, dsum[59:44]};
      end
      if (neg) begin
         if (q >= 17'd32768) begin
            r = 16'h8000;
         end else begin
            r = 16'(-q);
         end
      end else begin
         if (q > 17'd32767) begin
            r = 16'h7FFF;
         end else begin
            r = q[15:0];
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/magnetometer_field_and_heading.sv]
`default_nettype none

// Channel    Direction  Handshake            Payload
// request    in         req_valid/req_stall  six raw bytes, range mode
// response   out        rsp_valid/rsp_stall  status, field x/y/z, magnitude, angles, echoes
// csr        in         csr_write            csr_index, csr_wdata
//
// One request enters per cycle while req_stall is low; a request passes through the
// 32-stage square root followed by the unrolled CORDIC and the angle scaling.
// Reset is synchronous: it clears all valid bits and loads register defaults.
// A stalled response freezes the whole pipeline, so req_stall follows rsp_stall
// only while a response is held in the output register.

module magnetometer_field_and_heading #(
   parameter int unsigned CORDIC_STEPS = mfh_pkg::CORDIC_STEPS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_x_low,
   input  wire logic [7:0]                       req_x_high,
   input  wire logic [7:0]                       req_y_low,
   input  wire logic [7:0]                       req_y_high,
   input  wire logic [7:0]                       req_z_low,
   input  wire logic [7:0]                       req_z_high,
   input  wire logic                             req_range_mode,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_status,
   output logic signed [23:0]                    rsp_field_x,
   output logic signed [23:0]                    rsp_field_y,
   output logic signed [23:0]                    rsp_field_z,
   output logic [23:0]                           rsp_magnitude,
   output logic signed [15:0]                    rsp_azimuth,
   output logic signed [15:0]                    rsp_pitch,
   output logic                                  rsp_range_echo,
   output logic                                  rsp_unit_echo,
   input  wire logic                             csr_write,
   input  wire logic [mfh_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [mfh_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mfh_pkg::*;

   logic en;

   logic [15:0] scale_ff;
   logic        unit_ff;

   // Stage A: capture
   logic        a_valid_ff;
   side_type    a_side_ff;
   side_type    a_side_in;
   logic [15:0] a_scale_ff;

   // Stage B: products
   logic        b_valid_ff;
   side_type    b_side_ff;
   logic [30:0] b_sqx_ff, b_sqy_ff, b_sqz_ff;
   logic [31:0] b_px_ff, b_py_ff, b_pz_ff;
   logic [31:0] b_ss_ff;
   logic [16:0] b_ax_in, b_ay_in, b_az_in;
   logic signed [31:0] b_sqx_in, b_sqy_in, b_sqz_in;

   // Stage C: sums and field rounding
   logic        c_valid_ff;
   side_type    c_side_ff;
   side_type    c_side_in;
   logic [31:0] c_sxy_ff, c_s3_ff, c_ss_ff;
   logic [31:0] c_sxy_in, c_s3_in;

   // Square root pipeline
   logic [SQRT_STEPS:0] sq_valid_ff;
   sqrt_state_type      mag_ff [SQRT_STEPS+1];
   sqrt_state_type      rxy_ff [SQRT_STEPS+1];
   sqrt_state_type      mag_in [SQRT_STEPS+1];
   sqrt_state_type      rxy_in [SQRT_STEPS+1];
   side_type            sq_side_ff [SQRT_STEPS+1];
   logic [63:0]         prod_in;

   // CORDIC pipeline
   logic [CORDIC_STEPS:0] co_valid_ff;
   cordic_type            az_ff [CORDIC_STEPS+1];
   cordic_type            pt_ff [CORDIC_STEPS+1];
   cordic_type            az_in [CORDIC_STEPS+1];
   cordic_type            pt_in [CORDIC_STEPS+1];
   side_type              co_side_ff [CORDIC_STEPS+1];
   side_type              co_side_in;
   logic [24:0]           mag_round_in;

   // Stage F: angle scaling
   logic        f_valid_ff;
   side_type    f_side_ff;
   logic        f_az_neg_ff, f_pt_neg_ff;
   logic [30:0] f_az_m_ff, f_pt_m_ff;
   logic [59:0] f_az_p_ff, f_pt_p_ff;
   logic signed [ZW-1:0] f_az_z_in, f_pt_z_in;
   logic [30:0] f_az_m_in, f_pt_m_in;

   // Output register
   logic               g_valid_ff;
   logic               g_status_ff;
   logic signed [23:0] g_fx_ff, g_fy_ff, g_fz_ff;
   logic [23:0]        g_mag_ff;
   logic signed [15:0] g_az_ff, g_pt_ff;
   logic               g_range_ff, g_unit_ff;

   // Advance unless a response is held
   assign en        = !(g_valid_ff && rsp_stall);
   assign req_stall = !en;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= LSB_SCALE_RESET;
         unit_ff  <= ANGLE_UNIT_RESET;
      end else if (csr_write) begin
         if (csr_index == REG_LSB_SCALE) begin
            scale_ff <= csr_wdata[15:0];
         end
         if (csr_index == REG_ANGLE_UNIT) begin
            unit_ff <= csr_wdata[0];
         end
      end
   end

   // Decode the raw sample
   always_comb begin
      a_side_in            = '0;
      a_side_in.x          = $signed({req_x_high, req_x_low});
      a_side_in.y          = $signed({req_y_high, req_y_low});
      a_side_in.z          = $signed({req_z_high, req_z_low});
      a_side_in.range_b    = req_range_mode;
      a_side_in.unit       = unit_ff;
      a_side_in.scale_zero = (scale_ff == 16'd0);
      a_side_in.err        = !req_range_mode &&
                             ((req_x_high[7] ^ req_x_high[6]) ||
                              (req_y_high[7] ^ req_y_high[6]) ||
                              (req_z_high[7] ^ req_z_high[6]));
   end

   // Absolute values and squares
   always_comb begin
      b_ax_in  = a_side_ff.x[15] ? 17'(-{1'b1, a_side_ff.x}) : {1'b0, a_side_ff.x};
      b_ay_in  = a_side_ff.y[15] ? 17'(-{1'b1, a_side_ff.y}) : {1'b0, a_side_ff.y};
      b_az_in  = a_side_ff.z[15] ? 17'(-{1'b1, a_side_ff.z}) : {1'b0, a_side_ff.z};
      b_sqx_in = a_side_ff.x * a_side_ff.x;
      b_sqy_in = a_side_ff.y * a_side_ff.y;
      b_sqz_in = a_side_ff.z * a_side_ff.z;
   end

   // Sum squares, round the scaled axes
   always_comb begin
      logic [32:0] rx;
      logic [32:0] ry;
      logic [32:0] rz;
      c_sxy_in  = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
      c_s3_in   = c_sxy_in + {1'b0, b_sqz_ff};
      rx        = {1'b0, b_px_ff} + 33'd128;
      ry        = {1'b0, b_py_ff} + 33'd128;
      rz        = {1'b0, b_pz_ff} + 33'd128;
      c_side_in = b_side_ff;
      c_side_in.fx = b_side_ff.x[15] ? -$signed(rx[31:8]) : $signed(rx[31:8]);
      c_side_in.fy = b_side_ff.y[15] ? -$signed(ry[31:8]) : $signed(ry[31:8]);
      c_side_in.fz = b_side_ff.z[15] ? -$signed(rz[31:8]) : $signed(rz[31:8]);
   end

   // Square root stages
   always_comb begin
      prod_in   = c_s3_ff * c_ss_ff;
      mag_in[0] = '{rem: prod_in, root: 64'd0};
      rxy_in[0] = '{rem: {c_sxy_ff, 32'd0}, root: 64'd0};
      for (int k = 1; k <= SQRT_STEPS; k++) begin
         mag_in[k] = sqrt_step(mag_ff[k-1], k - 1);
         rxy_in[k] = sqrt_step(rxy_ff[k-1], k - 1);
      end
   end

   // CORDIC pre-rotation and micro-rotations
   always_comb begin
      mag_round_in = 25'((mag_ff[SQRT_STEPS].root[32:0] + 33'd128) >> 8);
      co_side_in   = sq_side_ff[SQRT_STEPS];
      co_side_in.mag = (mag_round_in > 25'hFFFFFF) ? 24'hFFFFFF : mag_round_in[23:0];
      az_in[0] = cordic_init(CW'(sq_side_ff[SQRT_STEPS].x) <<< 16,
                             CW'(sq_side_ff[SQRT_STEPS].y) <<< 16);
      pt_in[0] = cordic_init($signed({{(CW-32){1'b0}}, rxy_ff[SQRT_STEPS].root[31:0]}),
                             CW'(sq_side_ff[SQRT_STEPS].z) <<< 16);
      for (int i = 1; i <= CORDIC_STEPS; i++) begin
         az_in[i] = cordic_step(az_ff[i-1], i - 1);
         pt_in[i] = cordic_step(pt_ff[i-1], i - 1);
      end
   end

   // Drop angles for a zero vector or zero scale
   always_comb begin
      f_az_z_in = (az_ff[CORDIC_STEPS].zero || co_side_ff[CORDIC_STEPS].scale_zero) ?
                  '0 : az_ff[CORDIC_STEPS].z;
      f_pt_z_in = (pt_ff[CORDIC_STEPS].zero || co_side_ff[CORDIC_STEPS].scale_zero) ?
                  '0 : pt_ff[CORDIC_STEPS].z;
      f_az_m_in = f_az_z_in[ZW-1] ? 31'(-f_az_z_in) : f_az_z_in[30:0];
      f_pt_m_in = f_pt_z_in[ZW-1] ? 31'(-f_pt_z_in) : f_pt_z_in[30:0];
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         sq_valid_ff <= '0;
         co_valid_ff <= '0;
         f_valid_ff  <= 1'b0;
         g_valid_ff  <= 1'b0;
      end else if (en) begin
         a_valid_ff  <= req_valid;
         b_valid_ff  <= a_valid_ff;
         c_valid_ff  <= b_valid_ff;
         sq_valid_ff <= {sq_valid_ff[SQRT_STEPS-1:0], c_valid_ff};
         co_valid_ff <= {co_valid_ff[CORDIC_STEPS-1:0], sq_valid_ff[SQRT_STEPS]};
         f_valid_ff  <= co_valid_ff[CORDIC_STEPS];
         g_valid_ff  <= f_valid_ff;
      end
   end

   // Payload pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         a_side_ff  <= a_side_in;
         a_scale_ff <= scale_ff;

         b_side_ff <= a_side_ff;
         b_sqx_ff  <= b_sqx_in[30:0];
         b_sqy_ff  <= b_sqy_in[30:0];
         b_sqz_ff  <= b_sqz_in[30:0];
         b_px_ff   <= 32'(b_ax_in * a_scale_ff);
         b_py_ff   <= 32'(b_ay_in * a_scale_ff);
         b_pz_ff   <= 32'(b_az_in * a_scale_ff);
         b_ss_ff   <= a_scale_ff * a_scale_ff;

         c_side_ff <= c_side_in;
         c_sxy_ff  <= c_sxy_in;
         c_s3_ff   <= c_s3_in;
         c_ss_ff   <= b_ss_ff;

         for (int k = 0; k <= SQRT_STEPS; k++) begin
            mag_ff[k] <= mag_in[k];
            rxy_ff[k] <= rxy_in[k];
         end
         sq_side_ff[0] <= c_side_ff;
         for (int k = 1; k <= SQRT_STEPS; k++) begin
            sq_side_ff[k] <= sq_side_ff[k-1];
         end

         for (int i = 0; i <= CORDIC_STEPS; i++) begin
            az_ff[i] <= az_in[i];
            pt_ff[i] <= pt_in[i];
         end
         co_side_ff[0] <= co_side_in;
         for (int i = 1; i <= CORDIC_STEPS; i++) begin
            co_side_ff[i] <= co_side_ff[i-1];
         end

         f_side_ff   <= co_side_ff[CORDIC_STEPS];
         f_az_neg_ff <= f_az_z_in[ZW-1];
         f_pt_neg_ff <= f_pt_z_in[ZW-1];
         f_az_m_ff   <= f_az_m_in;
         f_pt_m_ff   <= f_pt_m_in;
         f_az_p_ff   <= 60'(f_az_m_in * DEG128_PER_RAD_Q16);
         f_pt_p_ff   <= 60'(f_pt_m_in * DEG128_PER_RAD_Q16);

         // Format the response; a format error zeroes everything but status
         if (f_side_ff.err) begin
            g_status_ff <= 1'b1;
            g_fx_ff     <= '0;
            g_fy_ff     <= '0;
            g_fz_ff     <= '0;
            g_mag_ff    <= '0;
            g_az_ff     <= '0;
            g_pt_ff     <= '0;
            g_range_ff  <= 1'b0;
            g_unit_ff   <= 1'b0;
         end else begin
            g_status_ff <= 1'b0;
            g_fx_ff     <= f_side_ff.fx;
            g_fy_ff     <= f_side_ff.fy;
            g_fz_ff     <= f_side_ff.fz;
            g_mag_ff    <= f_side_ff.mag;
            g_az_ff     <= $signed(angle_fmt(f_az_neg_ff, f_az_m_ff, f_az_p_ff,
                                             f_side_ff.unit));
            g_pt_ff     <= $signed(angle_fmt(f_pt_neg_ff, f_pt_m_ff, f_pt_p_ff,
                                             f_side_ff.unit));
            g_range_ff  <= f_side_ff.range_b;
            g_unit_ff   <= f_side_ff.unit;
         end
      end
   end

   assign rsp_valid      = g_valid_ff;
   assign rsp_status     = g_status_ff;
   assign rsp_field_x    = g_fx_ff;
   assign rsp_field_y    = g_fy_ff;
   assign rsp_field_z    = g_fz_ff;
   assign rsp_magnitude  = g_mag_ff;
   assign rsp_azimuth    = g_az_ff;
   assign rsp_pitch      = g_pt_ff;
   assign rsp_range_echo = g_range_ff;
   assign rsp_unit_echo  = g_unit_ff;

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import mfh_pkg::*;

   localparam int PIPE_DRAIN  = 60;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SPARE_B = 2'd3;

   typedef struct {
      logic [7:0] xl, xh, yl, yh, zl, zh;
      logic       rng;
   } sample_type;

   typedef struct packed {
      logic        status;
      logic [23:0] fx, fy, fz, mag;
      logic [15:0] az, pt;
      logic        re, ue;
   } heading_type;

   logic clock, reset;
   logic req_valid, req_stall;
   logic [7:0] req_x_low, req_x_high, req_y_low, req_y_high, req_z_low, req_z_high;
   logic req_range_mode;
   logic rsp_valid, rsp_stall, rsp_status, rsp_range_echo, rsp_unit_echo;
   logic signed [23:0] rsp_field_x, rsp_field_y, rsp_field_z;
   logic [23:0] rsp_magnitude;
   logic signed [15:0] rsp_azimuth, rsp_pitch;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   magnetometer_field_and_heading dut (.*);

   sample_type  pending[$];
   heading_type expected[$];
   logic [15:0] scale_cfg;
   logic        unit_cfg;
   logic        quiet;
   logic        req_taken;
   int  gap_left, stall_left, errors, cycles, accepted, checked, fmt_errs;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // floor square root, one bit at a time from the top
   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, c;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= v) r = c;
      end
      return r;
   endfunction

   // vectoring CORDIC, angle in Q28 radians
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, dx, dy;
      if (x == 0 && y == 0) return 0;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 2 * longint'(ATAN_Q28[0]);
         end else begin
            x = -y; y = t; z = -2 * longint'(ATAN_Q28[0]);
         end
      end
      for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += longint'(ATAN_Q28[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(ATAN_Q28[i]);
         end
      end
      return z;
   endfunction

   function automatic logic [15:0] angle_code(longint z, logic unit);
      longint unsigned m, q;
      longint r;
      m = (z < 0) ? -z : z;
      if (unit == UNIT_RADIANS) q = (m + (64'd1 << 14)) >> 15;
      else q = (m * longint'(DEG128_PER_RAD_Q16) + (64'd1 << 43)) >> 44;
      if (q > 32768) q = 32768;
      r = (z < 0) ? -longint'(q) : longint'(q);
      if (r > 32767) r = 32767;
      return r[15:0];
   endfunction

   function automatic logic [23:0] axis_field(longint r, logic [15:0] s);
      longint unsigned m;
      longint v;
      m = (r < 0) ? -r : r;
      v = (m * s + 128) >> 8;
      if (r < 0) v = -v;
      return v[23:0];
   endfunction

   function automatic heading_type predict_heading(sample_type s, logic [15:0] sc, logic u);
      heading_type h;
      longint rx, ry, rz, rxy;
      longint unsigned sxy, mag;
      h = '0;
      if (!s.rng && ((s.xh[7] ^ s.xh[6]) || (s.yh[7] ^ s.yh[6]) || (s.zh[7] ^ s.zh[6]))) begin
         h.status = 1;
         return h;
      end
      rx = longint'($signed({s.xh, s.xl}));
      ry = longint'($signed({s.yh, s.yl}));
      rz = longint'($signed({s.zh, s.zl}));
      h.fx = axis_field(rx, sc);
      h.fy = axis_field(ry, sc);
      h.fz = axis_field(rz, sc);
      sxy = rx * rx + ry * ry;
      mag = (floor_sqrt((sxy + rz * rz) * sc * sc) + 128) >> 8;
      h.mag = (mag > 24'hFFFFFF) ? 24'hFFFFFF : mag[23:0];
      if (sc != 0) begin
         rxy = floor_sqrt(sxy << 32);
         h.az = angle_code(vector_angle(ry * 65536, rx * 65536), u);
         h.pt = angle_code(vector_angle(rz * 65536, rxy), u);
      end
      h.re = s.rng;
      h.ue = u;
      return h;
   endfunction

   function automatic sample_type make_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                              logic rng);
      sample_type s;
      {s.xh, s.xl} = x;
      {s.yh, s.yl} = y;
      {s.zh, s.zl} = z;
      s.rng = rng;
      return s;
   endfunction

   // random axis: mostly in range for the given mode, sometimes small
   function automatic logic [15:0] rand_axis(logic rng);
      logic [15:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) == 0) v = 16'($signed(v[7:0]));
      if (!rng) v[15] = v[14];
      return v;
   endfunction

   function automatic sample_type rand_sample();
      sample_type s;
      logic rng;
      rng = $urandom_range(0, 1);
      s = make_sample(rand_axis(rng), rand_axis(rng), rand_axis(rng), rng);
      // broken 14-bit samples now and then
      if ($urandom_range(0, 9) == 0) begin
         s.rng = 0;
         case ($urandom_range(0, 2))
            0: s.xh[7] = ~s.xh[6];
            1: s.yh[7] = ~s.yh[6];
            default: s.zh[7] = ~s.zh[6];
         endcase
      end
      return s;
   endfunction

   task automatic csr_put(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      @(negedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= d;
      if (idx == REG_LSB_SCALE) scale_cfg = d;
      else if (idx == REG_ANGLE_UNIT) unit_cfg = d[0];
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_valid || expected.size() != 0) @(posedge clock);
      repeat (PIPE_DRAIN) @(posedge clock);
   endtask

   task automatic add_random(int n);
      for (int i = 0; i < n; i++) pending.push_back(rand_sample());
   endtask

   // stimulus and configuration phases
   initial begin
      reset = 1; req_valid = 0; rsp_stall = 0; csr_write = 0; csr_index = REG_LSB_SCALE;
      csr_wdata = 0; req_x_low = 0; req_x_high = 0; req_y_low = 0; req_y_high = 0;
      req_z_low = 0; req_z_high = 0; req_range_mode = 0;
      scale_cfg = LSB_SCALE_RESET; unit_cfg = ANGLE_UNIT_RESET; quiet = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, zero vector, quadrants, format errors per axis
      pending.push_back(make_sample(16'h0000, 16'h0000, 16'h0000, 1));
      pending.push_back(make_sample(16'h0000, 16'h0000, 16'h0000, 0));
      pending.push_back(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 1));
      pending.push_back(make_sample(16'h8000, 16'h8000, 16'h8000, 1));
      pending.push_back(make_sample(16'h3FFF, 16'hC000, 16'h3FFF, 0));
      pending.push_back(make_sample(16'hC000, 16'h3FFF, 16'hC000, 0));
      pending.push_back(make_sample(16'h8000, 16'h0000, 16'h0000, 1));
      pending.push_back(make_sample(16'hFF00, 16'h0100, 16'h0000, 1));
      pending.push_back(make_sample(16'hFF00, 16'hFF00, 16'h0000, 1));
      pending.push_back(make_sample(16'h0000, 16'h0100, 16'h7FFF, 1));
      pending.push_back(make_sample(16'h0000, 16'h0000, 16'h8000, 1));
      pending.push_back(make_sample(16'h4000, 16'h0000, 16'h0000, 0));
      pending.push_back(make_sample(16'h0000, 16'h8000, 16'h0000, 0));
      pending.push_back(make_sample(16'h0000, 16'h0000, 16'h4000, 0));
      pending.push_back(make_sample(16'h4000, 16'h0000, 16'h0000, 1));
      pending.push_back(make_sample(16'h00FF, 16'hFF01, 16'h0001, 0));
      add_random(280);
      drain();

      csr_put(REG_ANGLE_UNIT, 16'hFFFF);
      csr_put(REG_LSB_SCALE, 16'h0000);
      add_random(250);
      drain();

      csr_put(REG_LSB_SCALE, 16'hFFFF);
      add_random(250);
      drain();

      csr_put(REG_ANGLE_UNIT, 16'hFFFE);
      csr_put(REG_SPARE_A, 16'h1234);
      csr_put(REG_SPARE_B, 16'hFFFF);
      add_random(250);
      drain();

      csr_put(REG_LSB_SCALE, 16'h0001);
      csr_put(REG_ANGLE_UNIT, 16'h0001);
      add_random(250);
      drain();

      csr_put(REG_LSB_SCALE, 16'($urandom));
      csr_put(REG_ANGLE_UNIT, 16'($urandom));
      add_random(250);
      drain();

      // last stretch runs at full rate
      quiet = 1;
      csr_put(REG_LSB_SCALE, LSB_SCALE_RESET);
      csr_put(REG_ANGLE_UNIT, 16'h0000);
      add_random(300);
      drain();

      $display("%0d requests sent over seven register settings, %0d responses checked",
               accepted, checked);
      $display("%0d format errors, both angle units, scales 0, 1, 614, 65535 and random",
               fmt_errs);
      if (errors == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   // record acceptance and predict
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset && req_valid && !req_stall) begin
         expected.push_back(predict_heading('{req_x_low, req_x_high, req_y_low, req_y_high,
                                              req_z_low, req_z_high, req_range_mode},
                                            scale_cfg, unit_cfg));
         if (expected[$].status) fmt_errs++;
         accepted++;
      end
   end

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (req_valid && !req_taken) begin
         // hold until taken
      end else if (gap_left > 0) begin
         req_valid <= 0;
         gap_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         gap_left = $urandom_range(0, 2);
      end else if (pending.size() != 0) begin
         req_valid      <= 1;
         req_x_low      <= pending[0].xl;
         req_x_high     <= pending[0].xh;
         req_y_low      <= pending[0].yl;
         req_y_high     <= pending[0].yh;
         req_z_low      <= pending[0].zl;
         req_z_high     <= pending[0].zh;
         req_range_mode <= pending[0].rng;
         void'(pending.pop_front());
      end else begin
         req_valid <= 0;
      end
   end

   // response stall bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1;
         stall_left--;
      end else if (!quiet && !reset && $urandom_range(0, 6) == 0) begin
         rsp_stall <= 1;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic check_field(string name, logic [23:0] e, logic [23:0] a);
      if (e !== a) begin
         $display("%0t: %s mismatch, expected %h got %h", $realtime, name, e, a);
         errors++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected.size() == 0) begin
            $display("%0t: response with nothing outstanding", $realtime);
            errors++;
         end else begin
            check_field("status", expected[0].status, rsp_status);
            check_field("field_x", expected[0].fx, rsp_field_x);
            check_field("field_y", expected[0].fy, rsp_field_y);
            check_field("field_z", expected[0].fz, rsp_field_z);
            check_field("magnitude", expected[0].mag, rsp_magnitude);
            check_field("azimuth", expected[0].az, $unsigned(rsp_azimuth));
            check_field("pitch", expected[0].pt, $unsigned(rsp_pitch));
            check_field("range_echo", expected[0].re, rsp_range_echo);
            check_field("unit_echo", expected[0].ue, rsp_unit_echo);
            void'(expected.pop_front());
            checked++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses outstanding", $realtime, expected.size());
         $display("testbench: errors");
         $finish;
      end
   end

   initial begin
      errors = 0; cycles = 0; accepted = 0; checked = 0; fmt_errs = 0;
      gap_left = 0; stall_left = 0; req_taken = 0;
   end

endmodule

`default_nettype wire
